FILE: design/vpi_pkg.sv
// shared types, widths and constants of the velocity pi controller
package vpi_pkg;

    localparam int VPI_FRAC_BITS = 8;

    // input and output field widths
    localparam int SPEED_W   = 16;
    localparam int CMD_W     = 2;
    localparam int OFFSET_W  = 16;
    localparam int EST_W     = 12;
    localparam int DIST_W    = 12;
    localparam int TILT_W    = 17;
    localparam int DRIVE_W   = 21;

    // configuration register widths
    localparam int MOVE_STEP_W = 10;
    localparam int THRESH_W    = 12;
    localparam int SPD_GAIN_W  = 8;
    localparam int POS_GAIN_W  = 16;
    localparam int POS_LIM_W   = 17;
    localparam int TILT_LIM_W  = 16;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIM  = 3'd5;

    // reset values
    localparam logic [MOVE_STEP_W-1:0] MOVE_STEP_RST = 10'd130;
    localparam logic [THRESH_W-1:0]    THRESH_RST    = 12'd50;
    localparam logic [SPD_GAIN_W-1:0]  SPD_GAIN_RST  = 8'd13;
    localparam logic [POS_GAIN_W-1:0]  POS_GAIN_RST  = 16'd5308;
    localparam logic [POS_LIM_W-1:0]   POS_LIM_RST   = 17'd100000;
    localparam logic [TILT_LIM_W-1:0]  TILT_LIM_RST  = 16'd10240;

    // motion commands
    localparam logic [CMD_W-1:0] CMD_GO      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd2;

    // low-pass weights, 16 fraction bits
    localparam logic [15:0] WEIGHT_OLD = 16'd52429;
    localparam logic [15:0] WEIGHT_NEW = 16'd13107;
    localparam int WEIGHT_SHIFT = 16;
    localparam int GAIN_SHIFT   = 16;
    localparam int NEAR_MARGIN  = 10;

    // shared multiplier second operand, signed, holds any 16 bit unsigned value
    localparam int MUL_B_W = 17;

endpackage

FILE: design/vpi_if.sv
// item channels of the velocity pi controller
interface vpi_in_if;
    import vpi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SPEED_W-1:0]  wheel_speed;
    logic [CMD_W-1:0]           motion_command;
    logic signed [OFFSET_W-1:0] steer_offset;
    logic [EST_W-1:0]           speed_estimate;
    logic [DIST_W-1:0]          obstacle_distance;
    logic signed [TILT_W-1:0]   tilt_angle;

    modport source (output valid, wheel_speed, motion_command, steer_offset,
                    speed_estimate, obstacle_distance, tilt_angle, input ready);
    modport sink   (input valid, wheel_speed, motion_command, steer_offset,
                    speed_estimate, obstacle_distance, tilt_angle, output ready);
endinterface

interface vpi_out_if;
    import vpi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] velocity_drive;
    logic                      buzzer_on;
    logic                      clear_command;

    modport source (output valid, velocity_drive, buzzer_on, clear_command, input ready);
    modport sink   (input valid, velocity_drive, buzzer_on, clear_command, output ready);
endinterface

FILE: design/vpi_mul.sv
// shared signed multiplier with registered product
module vpi_mul
    import vpi_pkg::*;
#(
    parameter int A_W = 26
)(
    input  logic                          clk,
    input  logic signed [A_W-1:0]         a,
    input  logic signed [MUL_B_W-1:0]     b,
    output logic signed [A_W+MUL_B_W-1:0] prod_reg
);

    logic signed [A_W+MUL_B_W-1:0] prod_next;

    assign prod_next = A_W'(a) * MUL_B_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

FILE: design/velocity_pi_with_obstacle_limit_top.sv
// velocity pi controller: one drive value per control tick, one shared multiplier
// states per item: S_FILT_OLD, S_FILT_NEW, S_FILT_SUM, S_POS, S_GAIN_POS, S_DRIVE, S_OUT
// one item at a time; the four products of a tick go through one multiplier
// the input is taken again once the result is in the output register, even if not yet taken
// reset: filter, integrator and buzzer clear to zero, registers take their default values
module velocity_pi_with_obstacle_limit_top
    import vpi_pkg::*;
#(
    parameter int FRAC_BITS = VPI_FRAC_BITS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    vpi_in_if.sink                in_ch,
    vpi_out_if.source             out_ch
);

    localparam int FS_W     = SPEED_W + FRAC_BITS;
    localparam int POS_W    = POS_LIM_W + 1 + FRAC_BITS;
    localparam int PSUM_W   = POS_W + 2;
    localparam int MA_W     = POS_W;
    localparam int PROD_W   = MA_W + MUL_B_W;
    localparam int DACC_W   = PROD_W + GAIN_SHIFT + 1;
    localparam int DSHIFT   = FRAC_BITS + GAIN_SHIFT;
    localparam int DRES_W   = DACC_W - DSHIFT;
    localparam int MV_W     = 18;

    typedef enum logic [2:0] {
        S_IDLE, S_FILT_OLD, S_FILT_NEW, S_FILT_SUM,
        S_POS, S_GAIN_POS, S_DRIVE, S_OUT
    } state_t;

    state_t state_reg;

    logic [MOVE_STEP_W-1:0] move_step_reg;
    logic [THRESH_W-1:0]    thresh_reg;
    logic [SPD_GAIN_W-1:0]  spd_gain_reg;
    logic [POS_GAIN_W-1:0]  pos_gain_reg;
    logic [POS_LIM_W-1:0]   pos_lim_reg;
    logic [TILT_LIM_W-1:0]  tilt_lim_reg;

    logic signed [FS_W-1:0]     fs_reg;
    logic signed [POS_W-1:0]    pos_reg;
    logic                       buzzer_reg;
    logic signed [SPEED_W-1:0]  speed_reg;
    logic signed [OFFSET_W-1:0] mv_reg;
    logic                       fault_reg;
    logic signed [PROD_W-1:0]   prod1_reg;
    logic signed [DACC_W-1:0]   dacc_reg;

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] out_drive_reg;
    logic                      out_buzzer_reg;
    logic                      out_clear_reg;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    vpi_mul #(.A_W(MA_W)) u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = MA_W'(fs_reg);
        mul_b = MUL_B_W'(WEIGHT_OLD);
        unique case (state_reg)
            S_FILT_NEW:
            begin
                mul_a = MA_W'(speed_reg);
                mul_b = MUL_B_W'(WEIGHT_NEW);
            end
            S_POS:
            begin
                mul_a = MA_W'(fs_reg);
                mul_b = MUL_B_W'(spd_gain_reg);
            end
            S_GAIN_POS:
            begin
                mul_a = MA_W'(pos_reg);
                mul_b = MUL_B_W'(pos_gain_reg);
            end
            default:
            begin
                mul_a = MA_W'(fs_reg);
                mul_b = MUL_B_W'(WEIGHT_OLD);
            end
        endcase
    end

    // target movement, obstacle check and tilt check of the incoming item
    logic signed [MV_W-1:0]   mv_cmd;
    logic signed [MV_W-1:0]   mv_sum;
    logic signed [OFFSET_W-1:0] mv_sat;
    logic                     near;
    logic                     buzzer_next;
    logic [EST_W:0]           est_margin;
    logic [THRESH_W+1:0]      reduce;
    logic signed [TILT_W:0]   tilt_ext;
    logic signed [TILT_W:0]   tl_ext;
    logic                     fault_next;

    always_comb
    begin
        case (in_ch.motion_command)
            CMD_GO:      mv_cmd = MV_W'($signed({1'b0, move_step_reg}));
            CMD_REVERSE: mv_cmd = -MV_W'($signed({1'b0, move_step_reg}));
            default:     mv_cmd = '0;
        endcase
        est_margin  = (EST_W+1)'(in_ch.speed_estimate) + (EST_W+1)'(NEAR_MARGIN);
        near        = (est_margin > (EST_W+1)'(in_ch.obstacle_distance))
                      && (in_ch.obstacle_distance < thresh_reg);
        reduce      = (THRESH_W+2)'(in_ch.speed_estimate) + (THRESH_W+2)'(thresh_reg)
                      - (THRESH_W+2)'(in_ch.obstacle_distance);
        mv_sum      = mv_cmd;
        buzzer_next = buzzer_reg;
        if (in_ch.steer_offset != '0)
        begin
            if (near)
            begin
                buzzer_next = 1'b1;
                if (in_ch.steer_offset > 0)
                    mv_sum = mv_cmd - MV_W'($signed({1'b0, reduce}));
                else
                    mv_sum = mv_cmd + MV_W'(in_ch.steer_offset);
            end
            else
            begin
                buzzer_next = 1'b0;
                mv_sum      = mv_cmd + MV_W'(in_ch.steer_offset);
            end
        end
        if (mv_sum > MV_W'(32767))
            mv_sat = 16'sh7fff;
        else if (mv_sum < -MV_W'(32768))
            mv_sat = 16'sh8000;
        else
            mv_sat = mv_sum[OFFSET_W-1:0];
        tilt_ext   = (TILT_W+1)'(in_ch.tilt_angle);
        tl_ext     = (TILT_W+1)'($signed({1'b0, tilt_lim_reg}));
        fault_next = (tilt_ext > tl_ext) || (tilt_ext < -tl_ext);
    end

    // low-pass sum, truncated toward zero
    logic signed [PROD_W-1:0] facc;
    logic signed [PROD_W-1:0] facc_b;
    logic signed [FS_W-1:0]   fs_next;

    always_comb
    begin
        facc    = prod1_reg + (prod <<< FRAC_BITS);
        facc_b  = facc + (facc[PROD_W-1] ? PROD_W'((1 << WEIGHT_SHIFT) - 1) : '0);
        fs_next = facc_b[FS_W+WEIGHT_SHIFT-1:WEIGHT_SHIFT];
    end

    // integrator update with clamp, cleared to zero on a tilt fault
    logic signed [PSUM_W-1:0] psum;
    logic signed [PSUM_W-1:0] plim;
    logic signed [POS_W-1:0]  pos_next;

    always_comb
    begin
        psum = PSUM_W'(pos_reg) + PSUM_W'(fs_reg) + (PSUM_W'(mv_reg) <<< FRAC_BITS);
        plim = PSUM_W'($signed({1'b0, pos_lim_reg})) <<< FRAC_BITS;
        if (fault_reg)
            pos_next = '0;
        else if (psum > plim)
            pos_next = plim[POS_W-1:0];
        else if (psum < -plim)
            pos_next = POS_W'(-plim);
        else
            pos_next = psum[POS_W-1:0];
    end

    // drive: truncate toward zero, then saturate; zero on a tilt fault
    logic signed [DACC_W-1:0]  dacc_next;
    logic signed [DACC_W-1:0]  dacc_b;
    logic signed [DRES_W-1:0]  dres;
    logic signed [DRIVE_W-1:0] drive_next;

    always_comb
    begin
        dacc_next = (DACC_W'(prod1_reg) <<< GAIN_SHIFT) + DACC_W'(prod);
        dacc_b    = dacc_reg + (dacc_reg[DACC_W-1] ? DACC_W'((1 << DSHIFT) - 1) : '0);
        dres      = dacc_b[DACC_W-1:DSHIFT];
        if (fault_reg)
            drive_next = '0;
        else if (dres > DRES_W'(1048575))
            drive_next = 21'sh0fffff;
        else if (dres < -DRES_W'(1048576))
            drive_next = 21'sh100000;
        else
            drive_next = dres[DRIVE_W-1:0];
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            move_step_reg  <= MOVE_STEP_RST;
            thresh_reg     <= THRESH_RST;
            spd_gain_reg   <= SPD_GAIN_RST;
            pos_gain_reg   <= POS_GAIN_RST;
            pos_lim_reg    <= POS_LIM_RST;
            tilt_lim_reg   <= TILT_LIM_RST;
            fs_reg         <= '0;
            pos_reg        <= '0;
            buzzer_reg     <= 1'b0;
            speed_reg      <= '0;
            mv_reg         <= '0;
            fault_reg      <= 1'b0;
            prod1_reg      <= '0;
            dacc_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_drive_reg  <= '0;
            out_buzzer_reg <= 1'b0;
            out_clear_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MOVE_STEP: move_step_reg <= cfg_data[MOVE_STEP_W-1:0];
                    CFG_THRESH:    thresh_reg    <= cfg_data[THRESH_W-1:0];
                    CFG_SPD_GAIN:  spd_gain_reg  <= cfg_data[SPD_GAIN_W-1:0];
                    CFG_POS_GAIN:  pos_gain_reg  <= cfg_data[POS_GAIN_W-1:0];
                    CFG_POS_LIM:   pos_lim_reg   <= cfg_data[POS_LIM_W-1:0];
                    CFG_TILT_LIM:  tilt_lim_reg  <= cfg_data[TILT_LIM_W-1:0];
                    default: ;
                endcase
            end

            // in S_OUT the output register is handled by the state below
            if (out_valid_reg && out_ch.ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        speed_reg  <= in_ch.wheel_speed;
                        mv_reg     <= mv_sat;
                        buzzer_reg <= buzzer_next;
                        fault_reg  <= fault_next;
                        state_reg  <= S_FILT_OLD;
                    end
                end
                S_FILT_OLD: state_reg <= S_FILT_NEW;
                S_FILT_NEW:
                begin
                    prod1_reg <= prod;
                    state_reg <= S_FILT_SUM;
                end
                S_FILT_SUM:
                begin
                    fs_reg    <= fs_next;
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    pos_reg   <= pos_next;
                    state_reg <= S_GAIN_POS;
                end
                S_GAIN_POS:
                begin
                    prod1_reg <= prod;
                    state_reg <= S_DRIVE;
                end
                S_DRIVE:
                begin
                    dacc_reg  <= dacc_next;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // wait for the output register to be free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_drive_reg  <= drive_next;
                        out_buzzer_reg <= buzzer_reg;
                        out_clear_reg  <= fault_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.velocity_drive = out_drive_reg;
    assign out_ch.buzzer_on      = out_buzzer_reg;
    assign out_ch.clear_command  = out_clear_reg;

endmodule
